>>> hdl/pdbs_pkg.sv
package pdbs_pkg;

   localparam int unsigned MAX_RESULTS = 16;
   localparam int unsigned RES_IDX_W = 4;
   localparam int unsigned RES_CNT_W = 5;
   localparam int unsigned ID_W = 5;
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 80;
   localparam int unsigned CSR_ADDR_W = 3;

   typedef enum logic [1:0] {
      KIND_ENQUEUE  = 2'd0,
      KIND_CANCEL   = 2'd1,
      KIND_DISPATCH = 2'd2,
      KIND_COMPLETE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STAT_QUEUED     = 3'd0,
      STAT_DISPATCHED = 3'd1,
      STAT_CANCELLED  = 3'd2,
      STAT_FULL       = 3'd3,
      STAT_IGNORED    = 3'd4,
      STAT_COMPLETED  = 3'd5
   } status_type;

   localparam logic REG_MAX_BATCH = 1'b0;
   localparam logic REG_BATCH_CAP = 1'b1;

endpackage

>>> hdl/pdbs_ram.sv
module pdbs_ram #(
   parameter int unsigned WIDTH = 5,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/prefill_decode_batch_scheduler.sv
// channel | ports  | word fields (lsb first)
// request | req_*  | tdata: ticket_id[4:0] position[20:5] prefilling[21]; tuser: kind
// result  | rsp_*  | tdata: out_ticket[4:0] batch_count[8:5] prefill_batch[9]
//         |        |        steps_done[41:10] batch_total[73:42] largest_batch[77:74]
//         |        | tuser: status; tlast: last
// config  | csr_*  | 0x0 max_decode_batch, 0x4 batch_capable
// enqueue, complete: one result each; cancel: no result
// dispatch: per popped entry ST_POP_RD then ST_POP_CHK (registered fifo ram read);
//   a final ST_POP_RD closes, then the up to 16 buffered results are replayed
// req_tready is high only while idle; a stalled result holds in the output buffer
// synchronous reset clears counts, pointers, cancel marks and counters; no clearing pass
module prefill_decode_batch_scheduler #(
   parameter int unsigned QUEUE_DEPTH  = 16,
   parameter int unsigned TICKET_COUNT = 32,
   parameter int unsigned STREAK_LIMIT = 8,
   parameter int unsigned BATCH_CAP    = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pdbs_pkg::REQ_DATA_W-1:0] req_tdata,  // ticket_id, position, prefilling
   input  logic [1:0]                    req_tuser,  // kind
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pdbs_pkg::RSP_DATA_W-1:0] rsp_tdata,  // out_ticket, batch_count,
                                                       // prefill_batch, steps_done,
                                                       // batch_total, largest_batch
   output logic [2:0]                    rsp_tuser,  // status
   output logic                          rsp_tlast,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [pdbs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import pdbs_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned MARK_N = (TICKET_COUNT < 32) ? TICKET_COUNT : 32;
   localparam int unsigned MIDX_W = (MARK_N > 1) ? $clog2(MARK_N) : 1;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_POP_RD  = 4'b0010,
      ST_POP_CHK = 4'b0100,
      ST_EMIT    = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [3:0] mdb_ff, mdb_in;
   logic bcap_ff, bcap_in;
   logic [CNT_W-1:0] pcnt_ff, pcnt_in, dcnt_ff, dcnt_in;
   logic [PTR_W-1:0] phead_ff, phead_in, ptail_ff, ptail_in;
   logic [PTR_W-1:0] dhead_ff, dhead_in, dtail_ff, dtail_in;
   logic [MARK_N-1:0] marks_ff, marks_in;
   logic [3:0] streak_ff, streak_in;
   logic [3:0] run_ff, run_in;
   logic run_pf_ff, run_pf_in;
   logic [31:0] total_ff, total_in, multi_ff, multi_in;
   logic [3:0] big_ff, big_in;
   logic use_pf_ff, use_pf_in;
   logic [3:0] limit_ff, limit_in, taken_ff, taken_in;
   logic [RES_CNT_W-1:0] nres_ff, nres_in;
   logic [RES_IDX_W-1:0] ridx_ff, ridx_in;
   logic [3:0] bc_ff, bc_in;

   logic [ID_W-1:0] tick_buf_ff [MAX_RESULTS];
   status_type stat_buf_ff [MAX_RESULTS];
   logic buf_we;
   logic [ID_W-1:0] buf_tick;
   status_type buf_stat;

   logic pwr_en, dwr_en;
   logic [ID_W-1:0] prd_data, drd_data, pop_tick;

   logic [ID_W-1:0] in_id;
   logic [15:0] in_pos;
   logic in_pre, to_pf, accept, emit_go;
   kind_type in_kind;
   logic [3:0] cap, room, lim;
   logic [4:0] streak_sum;
   logic pop_marked;
   logic [MIDX_W-1:0] mid;
   status_type out_stat;

   pdbs_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_pf_ram (
      .clock, .wr_en(pwr_en), .wr_addr(ptail_ff), .wr_data(in_id),
      .rd_addr(phead_ff), .rd_data(prd_data)
   );
   pdbs_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_dc_ram (
      .clock, .wr_en(dwr_en), .wr_addr(dtail_ff), .wr_data(in_id),
      .rd_addr(dhead_ff), .rd_data(drd_data)
   );

   assign in_id   = req_tdata[4:0];
   assign in_pos  = req_tdata[20:5];
   assign in_pre  = req_tdata[21];
   assign in_kind = kind_type'(req_tuser);
   assign to_pf   = (in_pos == 16'd0) || in_pre;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept  = req_tvalid && req_tready;
   assign emit_go = rsp_tvalid && rsp_tready;
   assign pop_tick = use_pf_ff ? prd_data : drd_data;
   assign cap  = (mdb_ff > 4'(BATCH_CAP)) ? 4'(BATCH_CAP) : mdb_ff;
   assign room = 4'(STREAK_LIMIT) - streak_ff;

   assign pwr_en = accept && in_kind == KIND_ENQUEUE && to_pf
                   && pcnt_ff < CNT_W'(QUEUE_DEPTH);
   assign dwr_en = accept && in_kind == KIND_ENQUEUE && !to_pf
                   && dcnt_ff < CNT_W'(QUEUE_DEPTH);

   always_comb begin
      state_in  = state_ff;
      mdb_in    = mdb_ff;
      bcap_in   = bcap_ff;
      pcnt_in   = pcnt_ff;
      dcnt_in   = dcnt_ff;
      phead_in  = phead_ff;
      ptail_in  = ptail_ff;
      dhead_in  = dhead_ff;
      dtail_in  = dtail_ff;
      marks_in  = marks_ff;
      streak_in = streak_ff;
      run_in    = run_ff;
      run_pf_in = run_pf_ff;
      total_in  = total_ff;
      multi_in  = multi_ff;
      big_in    = big_ff;
      use_pf_in = use_pf_ff;
      limit_in  = limit_ff;
      taken_in  = taken_ff;
      nres_in   = nres_ff;
      ridx_in   = ridx_ff;
      bc_in     = bc_ff;
      buf_we    = 1'b0;
      buf_tick  = in_id;
      buf_stat  = STAT_IGNORED;
      lim       = 4'd1;
      streak_sum = 5'd0;
      mid       = MIDX_W'(in_id);
      pop_marked = 1'b0;

      if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[2])
            REG_MAX_BATCH: begin
               if (csr_pwdata[3:0] >= 4'd1 && csr_pwdata[3:0] <= 4'(BATCH_CAP)
                   && pcnt_ff == '0 && dcnt_ff == '0 && run_ff == 4'd0) begin
                  mdb_in = csr_pwdata[3:0];
               end
            end
            REG_BATCH_CAP: bcap_in = csr_pwdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ridx_in = '0;
               nres_in = RES_CNT_W'(1);
               bc_in   = 4'd0;
               unique case (in_kind)
                  KIND_ENQUEUE: begin
                     buf_we    = 1'b1;
                     use_pf_in = to_pf;
                     state_in  = ST_EMIT;
                     if (pwr_en || dwr_en) begin
                        buf_stat = STAT_QUEUED;
                        if (32'(in_id) < TICKET_COUNT) marks_in[mid] = 1'b0;
                        if (to_pf) begin
                           pcnt_in  = pcnt_ff + 1'b1;
                           ptail_in = (ptail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                      : ptail_ff + 1'b1;
                        end else begin
                           dcnt_in  = dcnt_ff + 1'b1;
                           dtail_in = (dtail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                      : dtail_ff + 1'b1;
                        end
                     end else begin
                        buf_stat = STAT_FULL;
                     end
                  end
                  KIND_CANCEL: begin
                     if (32'(in_id) < TICKET_COUNT) marks_in[mid] = 1'b1;
                  end
                  KIND_DISPATCH: begin
                     if (run_ff != 4'd0 || (pcnt_ff == '0 && dcnt_ff == '0)) begin
                        buf_we    = 1'b1;
                        buf_tick  = '0;
                        use_pf_in = 1'b0;
                        state_in  = ST_EMIT;
                     end else begin
                        use_pf_in = pcnt_ff != '0
                           && (dcnt_ff == '0 || streak_ff >= 4'(STREAK_LIMIT));
                        if (!use_pf_in && bcap_ff) lim = cap;
                        if (!use_pf_in && pcnt_ff != '0 && lim > room) lim = room;
                        limit_in = lim;
                        taken_in = 4'd0;
                        nres_in  = '0;
                        state_in = ST_POP_RD;
                     end
                  end
                  KIND_COMPLETE: begin
                     buf_we   = 1'b1;
                     buf_tick = '0;
                     state_in = ST_EMIT;
                     if (run_ff == 4'd0) begin
                        use_pf_in = 1'b0;
                     end else begin
                        buf_stat  = STAT_COMPLETED;
                        bc_in     = run_ff;
                        use_pf_in = run_pf_ff;
                        total_in  = total_ff + 32'(run_ff);
                        if (run_ff > 4'd1) begin
                           multi_in = multi_ff + 32'd1;
                           if (run_ff > big_ff) big_in = run_ff;
                        end
                        run_in    = 4'd0;
                        run_pf_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_POP_RD: begin
            // the selected head is on the ram read port this cycle
            if ((use_pf_ff ? pcnt_ff == '0 : dcnt_ff == '0) || taken_ff == limit_ff
                || nres_ff == RES_CNT_W'(MAX_RESULTS)) begin
               ridx_in  = '0;
               bc_in    = taken_ff;
               state_in = ST_EMIT;
               if (taken_ff != 4'd0) begin
                  run_in    = taken_ff;
                  run_pf_in = use_pf_ff;
                  if (use_pf_ff) begin
                     streak_in = 4'd0;
                  end else begin
                     streak_sum = {1'b0, streak_ff} + {1'b0, taken_ff};
                     streak_in = (streak_sum > 5'(STREAK_LIMIT)) ? 4'(STREAK_LIMIT)
                                 : streak_sum[3:0];
                  end
               end
            end else begin
               state_in = ST_POP_CHK;
            end
         end
         ST_POP_CHK: begin
            mid = MIDX_W'(pop_tick);
            pop_marked = (32'(pop_tick) < TICKET_COUNT) && marks_ff[mid];
            buf_we   = 1'b1;
            buf_tick = pop_tick;
            if (pop_marked) begin
               buf_stat = STAT_CANCELLED;
               marks_in[mid] = 1'b0;
            end else begin
               buf_stat = STAT_DISPATCHED;
               taken_in = taken_ff + 1'b1;
            end
            nres_in = nres_ff + 1'b1;
            if (use_pf_ff) begin
               pcnt_in  = pcnt_ff - 1'b1;
               phead_in = (phead_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : phead_ff + 1'b1;
            end else begin
               dcnt_in  = dcnt_ff - 1'b1;
               dhead_in = (dhead_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : dhead_ff + 1'b1;
            end
            state_in = ST_POP_RD;
         end
         ST_EMIT: begin
            if (emit_go) begin
               ridx_in = ridx_ff + 1'b1;
               if (rsp_tlast) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         mdb_ff    <= 4'd1;
         bcap_ff   <= 1'b0;
         pcnt_ff   <= '0;
         dcnt_ff   <= '0;
         phead_ff  <= '0;
         ptail_ff  <= '0;
         dhead_ff  <= '0;
         dtail_ff  <= '0;
         marks_ff  <= '0;
         streak_ff <= 4'd0;
         run_ff    <= 4'd0;
         run_pf_ff <= 1'b0;
         total_ff  <= 32'd0;
         multi_ff  <= 32'd0;
         big_ff    <= 4'd0;
         nres_ff   <= '0;
         ridx_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         mdb_ff    <= mdb_in;
         bcap_ff   <= bcap_in;
         pcnt_ff   <= pcnt_in;
         dcnt_ff   <= dcnt_in;
         phead_ff  <= phead_in;
         ptail_ff  <= ptail_in;
         dhead_ff  <= dhead_in;
         dtail_ff  <= dtail_in;
         marks_ff  <= marks_in;
         streak_ff <= streak_in;
         run_ff    <= run_in;
         run_pf_ff <= run_pf_in;
         total_ff  <= total_in;
         multi_ff  <= multi_in;
         big_ff    <= big_in;
         nres_ff   <= nres_in;
         ridx_ff   <= ridx_in;
      end
      use_pf_ff <= use_pf_in;
      limit_ff  <= limit_in;
      taken_ff  <= taken_in;
      bc_ff     <= bc_in;
      // single-result items always land in slot zero
      if (buf_we) begin
         tick_buf_ff[state_ff == ST_POP_CHK ? nres_ff[RES_IDX_W-1:0] : '0] <= buf_tick;
         stat_buf_ff[state_ff == ST_POP_CHK ? nres_ff[RES_IDX_W-1:0] : '0] <= buf_stat;
      end
   end

   assign out_stat   = stat_buf_ff[ridx_ff];
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tuser  = out_stat;
   assign rsp_tlast  = ({1'b0, ridx_ff} + 1'b1) == nres_ff;
   assign rsp_tdata  = {2'b00, big_ff, multi_ff, total_ff, use_pf_ff,
                        (out_stat == STAT_DISPATCHED || out_stat == STAT_COMPLETED)
                           ? bc_ff : 4'd0,
                        tick_buf_ff[ridx_ff]};

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_BATCH_CAP) ? {31'd0, bcap_ff} : {28'd0, mdb_ff};
endmodule

>>> hdl/pdbs_checker.sv
module pdbs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [pdbs_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [1:0]                    req_tuser,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [pdbs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [2:0]                    rsp_tuser,
   input logic                          rsp_tlast,
   input logic                          csr_psel,
   input logic                          csr_penable,
   input logic                          csr_pwrite,
   input logic [pdbs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [31:0]                   csr_pwdata,
   input logic [31:0]                   csr_prdata,
   input logic                          csr_pready
);
   import pdbs_pkg::*;

   // one item at a time: a taken word closes the request side, except a cancel
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser != KIND_CANCEL |=> !req_tready)
      else $error("request accepted while busy");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request side open during results");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("block not idle after final result");
endmodule

bind prefill_decode_batch_scheduler pdbs_checker u_pdbs_checker (.*);

>>> tb/sv/sched_checker.sv
module sched_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [pdbs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                     req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [pdbs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [2:0]                     rsp_tuser,
   input  logic                           rsp_tlast,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pdbs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output int                             fail_count,
   output int                             pending
);
   import pdbs_pkg::*;

   typedef struct packed {
      logic [4:0]  ticket;
      logic [2:0]  status;
      logic [3:0]  count;
      logic        pf;
      logic        last;
      logic [31:0] steps;
      logic [31:0] multi;
      logic [3:0]  largest;
   } sched_word_type;

   sched_word_type word_q[$];

   logic [4:0]  pre_q[$];
   logic [4:0]  dec_q[$];
   logic [31:0] marked;
   logic [3:0]  cfg_batch;
   logic        cfg_cap;
   int          streak;
   int          busy_n;
   logic        busy_pf;
   logic [31:0] done_total;
   logic [31:0] multi_total;
   logic [3:0]  biggest;

   task automatic push_word(input logic [4:0] t, input status_type s, input logic [3:0] c,
                            input logic p);
      sched_word_type w;
      w = '0;
      w.ticket = t; w.status = s; w.count = c; w.pf = p;
      word_q.insert(word_q.size(), w);
   endtask

   task automatic schedule_item(input kind_type k, input logic [4:0] id,
                                input logic [15:0] pos, input logic pre);
      int base, n, lim, taken, i;
      logic use_pf, to_pf;
      logic [4:0] t;
      base = word_q.size();
      case (k)
         KIND_ENQUEUE: begin
            to_pf = (pos == 0) || pre;
            if ((to_pf ? pre_q.size() : dec_q.size()) >= 16) begin
               push_word(id, STAT_FULL, 4'd0, to_pf);
            end else begin
               if (to_pf) pre_q.insert(pre_q.size(), id); else dec_q.insert(dec_q.size(), id);
               marked[id] = 1'b0;
               push_word(id, STAT_QUEUED, 4'd0, to_pf);
            end
         end
         KIND_CANCEL: marked[id] = 1'b1;
         KIND_DISPATCH: begin
            if (busy_n != 0 || (pre_q.size() == 0 && dec_q.size() == 0)) begin
               push_word(5'd0, STAT_IGNORED, 4'd0, 1'b0);
            end else begin
               use_pf = pre_q.size() != 0 && (dec_q.size() == 0 || streak >= 8);
               lim = (use_pf || !cfg_cap) ? 1 : int'(cfg_batch);
               if (!use_pf && pre_q.size() != 0 && lim > 8 - streak) lim = 8 - streak;
               taken = 0; n = 0;
               while ((use_pf ? pre_q.size() : dec_q.size()) != 0 && taken < lim
                      && n < MAX_RESULTS) begin
                  if (use_pf) begin
                     t = pre_q[0]; pre_q.delete(0);
                  end else begin
                     t = dec_q[0]; dec_q.delete(0);
                  end
                  if (marked[t]) begin
                     marked[t] = 1'b0;
                     push_word(t, STAT_CANCELLED, 4'd0, use_pf);
                  end else begin
                     push_word(t, STAT_DISPATCHED, 4'd0, use_pf);
                     taken++;
                  end
                  n++;
               end
               if (taken != 0) begin
                  for (i = base; i < word_q.size(); i++)
                     if (word_q[i].status == STAT_DISPATCHED) word_q[i].count = 4'(taken);
                  busy_n = taken; busy_pf = use_pf;
                  if (use_pf) streak = 0;
                  else streak = (streak + taken > 8) ? 8 : streak + taken;
               end
            end
         end
         default: begin
            if (busy_n == 0) begin
               push_word(5'd0, STAT_IGNORED, 4'd0, 1'b0);
            end else begin
               done_total += 32'(busy_n);
               if (busy_n > 1) begin
                  multi_total += 1;
                  if (busy_n > int'(biggest)) biggest = 4'(busy_n);
               end
               push_word(5'd0, STAT_COMPLETED, 4'(busy_n), busy_pf);
               busy_n = 0; busy_pf = 0;
            end
         end
      endcase
      for (i = base; i < word_q.size(); i++) begin
         word_q[i].steps = done_total;
         word_q[i].multi = multi_total;
         word_q[i].largest = biggest;
      end
      if (word_q.size() > base) word_q[word_q.size()-1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      sched_word_type got, want;
      if (reset) begin
         word_q.delete(); pre_q.delete(); dec_q.delete();
         marked = '0; cfg_batch = 4'd1; cfg_cap = 1'b0;
         streak = 0; busy_n = 0; busy_pf = 0;
         done_total = 0; multi_total = 0; biggest = 0; fail_count <= 0;
         pending = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr == 3'd0) begin
               if (csr_pwdata[3:0] >= 1 && csr_pwdata[3:0] <= 8 && pre_q.size() == 0 &&
                   dec_q.size() == 0 && busy_n == 0)
                  cfg_batch = csr_pwdata[3:0];
            end else if (csr_paddr == 3'd4) begin
               cfg_cap = csr_pwdata[0];
            end
         end
         if (req_tvalid && req_tready)
            schedule_item(kind_type'(req_tuser), req_tdata[4:0], req_tdata[20:5],
                          req_tdata[21]);
         if (rsp_tvalid && rsp_tready) begin
            got.ticket = rsp_tdata[4:0];   got.count = rsp_tdata[8:5];
            got.pf = rsp_tdata[9];         got.steps = rsp_tdata[41:10];
            got.multi = rsp_tdata[73:42];  got.largest = rsp_tdata[77:74];
            got.status = rsp_tuser;        got.last = rsp_tlast;
            if (word_q.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = word_q[0];
               word_q.delete(0);
               if (got !== want) begin
                  $display("%0t: mismatch, expected %h, actual %h", $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending = word_q.size();
      end
   end
endmodule

>>> tb/sv/testbench.sv
module testbench;
   import pdbs_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0, req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // ticket_id, position, prefilling
   logic [1:0] req_tuser = '0;             // kind
   logic rsp_tvalid, rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // out_ticket, batch_count, prefill_batch,
                                           // steps_done, batch_total, largest_batch
   logic [2:0] rsp_tuser;                  // status
   logic rsp_tlast;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0, csr_prdata;
   logic csr_pready;
   int fail_count, pending;
   int idle_cycles = 0;
   bit hold_rsp = 0;

   always #10 clock = ~clock;

   prefill_decode_batch_scheduler dut (.*);

   sched_checker checker_i (.*);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: random stalls, with one long hold-off on request
   initial begin
      int g;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         g = $urandom_range(0, 9);
         if (g < 6) rsp_tready <= 1;
         else if (g < 9) rsp_tready <= 0;
         else begin
            rsp_tready <= 0;
            repeat ($urandom_range(5, 40)) @(posedge clock);
            rsp_tready <= 1;
         end
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] a, input logic [31:0] d);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1; csr_paddr <= a; csr_pwdata <= d;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   // valid stays up after a taken word so the next word can follow directly
   task automatic send_word(input kind_type k, input logic [4:0] id,
                            input logic [15:0] pos, input logic pre);
      int g;
      g = $urandom_range(0, 19);
      if (g < 4) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end else if (g == 4) begin
         req_tvalid <= 0;
         repeat ($urandom_range(20, 60)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= k;
      req_tdata <= {2'b00, pre, pos, id};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic random_word(input int dec_bias);
      int r;
      logic [15:0] pos;
      r = $urandom_range(0, 99);
      pos = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
      if (r < 45) send_word(KIND_ENQUEUE, 5'($urandom), pos, 1'($urandom_range(0, dec_bias)));
      else if (r < 55) send_word(KIND_CANCEL, 5'($urandom), 16'($urandom), 1'($urandom));
      else if (r < 80) send_word(KIND_DISPATCH, 5'($urandom), 16'($urandom), 1'($urandom));
      else send_word(KIND_COMPLETE, 5'($urandom), 16'($urandom), 1'($urandom));
   endtask

   initial begin
      int i, ph;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: prefill enqueues, cancel, full queue, ignored events
      send_word(KIND_DISPATCH, 0, 0, 0);
      send_word(KIND_COMPLETE, 0, 0, 0);
      send_word(KIND_ENQUEUE, 5'd0, 16'd0, 0);
      send_word(KIND_ENQUEUE, 5'd31, 16'hFFFF, 1);
      send_word(KIND_ENQUEUE, 5'd7, 16'hFFFF, 0);
      send_word(KIND_CANCEL, 5'd0, 16'd0, 0);
      send_word(KIND_DISPATCH, 0, 0, 0);
      send_word(KIND_DISPATCH, 0, 0, 0);
      send_word(KIND_COMPLETE, 0, 0, 0);
      for (i = 0; i < 17; i++) send_word(KIND_ENQUEUE, 5'(i), 16'd1, 0);
      drain();
      for (ph = 0; ph < 6; ph++) begin
         // emptying queues lets the batch size write stick
         while (1) begin
            send_word(KIND_COMPLETE, 0, 0, 0);
            send_word(KIND_DISPATCH, 0, 0, 0);
            send_word(KIND_COMPLETE, 0, 0, 0);
            drain();
            if (rsp_tuser == STAT_IGNORED && $urandom_range(0, 3) != 0) break;
            if ($urandom_range(0, 40) == 0) break;
         end
         case (ph)
            0: begin csr_write(3'd0, 8); csr_write(3'd4, 1); end
            1: begin csr_write(3'd0, 1); csr_write(3'd4, 1); end
            2: begin csr_write(3'd0, 0); csr_write(3'd4, 0); end
            3: begin csr_write(3'd0, 15); csr_write(3'd4, 1); end
            4: begin csr_write(3'd0, $urandom_range(2, 7)); csr_write(3'd4, 1); end
            default: begin csr_write(3'd0, 32'hFFFF_FFF9); csr_write(3'd4, 32'hFFFF_FFFE); end
         endcase
         if (ph == 2) hold_rsp = 1;
         for (i = 0; i < 65; i++) random_word(ph == 3 ? 0 : 1);
         // all-cancelled batch
         if (ph == 1) begin
            send_word(KIND_ENQUEUE, 5'd3, 16'd9, 0);
            send_word(KIND_CANCEL, 5'd3, 0, 0);
         end
         drain();
      end
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
